### hw/rtl/tll_pkg.sv
// Shared types and constants for the toy language lexer.
// Beat payload structs, token, symbol and held-symbol codes, keyword table.
// No dependencies.
package tll_pkg;

    localparam int PosBits = 16;
    localparam logic [PosBits-1:0] PosMax = {PosBits{1'b1}};

    typedef enum logic [3:0] {
        KindKeyword    = 4'd0,
        KindIdentifier = 4'd1,
        KindOperator   = 4'd2,
        KindNumber     = 4'd3,
        KindFloat      = 4'd4,
        KindSemicolon  = 4'd5,
        KindOpenParen  = 4'd6,
        KindCloseParen = 4'd7,
        KindBracket    = 4'd8,
        KindComparison = 4'd9,
        KindAssignment = 4'd10,
        KindMistake    = 4'd11
    } kind_t;

    typedef enum logic [4:0] {
        SymNone     = 5'd0,
        SymPlus     = 5'd1,
        SymMinus    = 5'd2,
        SymStar     = 5'd3,
        SymSlash    = 5'd4,
        SymLParen   = 5'd5,
        SymRParen   = 5'd6,
        SymLBracket = 5'd7,
        SymRBracket = 5'd8,
        SymSemi     = 5'd9,
        SymEq       = 5'd10,
        SymEqEq     = 5'd11,
        SymNe       = 5'd12,
        SymGt       = 5'd13,
        SymGe       = 5'd14,
        SymLt       = 5'd15,
        SymLe       = 5'd16,
        SymAssign   = 5'd17
    } sym_t;

    typedef enum logic [2:0] {
        HeldNone  = 3'd0,
        HeldEq    = 3'd1,
        HeldBang  = 3'd2,
        HeldGt    = 3'd3,
        HeldLt    = 3'd4,
        HeldColon = 3'd5
    } held_t;

    typedef enum logic [1:0] {
        ClassAlpha = 2'd0,
        ClassDigit = 2'd1,
        ClassOther = 2'd2
    } class_t;

    localparam int KwCount = 10;
    localparam int KwMaxLen = 5;

    // characters packed first at [7:0]
    localparam logic [8*KwMaxLen-1:0] KwText [KwCount] = '{
        40'h00_00_74_6E_69,   // int
        40'h74_61_6F_6C_66,   // float
        40'h00_00_00_66_69,   // if
        40'h65_6C_69_68_77,   // while
        40'h00_65_73_6C_65,   // else
        40'h00_00_72_74_73,   // str
        40'h6E_69_67_65_62,   // begin
        40'h00_00_64_6E_65,   // end
        40'h00_00_6E_69_63,   // cin
        40'h00_74_75_6F_63    // cout
    };
    localparam logic [2:0] KwLen [KwCount] = '{
        3'd3, 3'd5, 3'd2, 3'd5, 3'd4, 3'd3, 3'd5, 3'd3, 3'd3, 3'd4
    };

    typedef struct packed {
        logic [7:0] character;
        logic       end_of_input;
    } in_t;

    typedef struct packed {
        kind_t               token_kind;
        sym_t                symbol_code;
        logic [3:0]          keyword_code;
        logic [PosBits-1:0]  start_position;
        logic [PosBits-1:0]  token_length;
        logic [31:0]         integer_part;
        logic [29:0]         fraction_digits;
        logic [3:0]          fraction_count;
        logic                last_of_run;
    } out_t;

    function automatic logic [3:0] keyword_of(
        input logic [8*KwMaxLen-1:0] text,
        input logic [PosBits-1:0]    len
    );
        logic [3:0] code;
        logic       hit;
        code = 4'd0;
        for (int i = 0; i < KwCount; i++) begin
            hit = (len == PosBits'(KwLen[i]));
            for (int j = 0; j < KwMaxLen; j++) begin
                if (j < int'(KwLen[i]) && text[8*j +: 8] != KwText[i][8*j +: 8]) begin
                    hit = 1'b0;
                end
            end
            if (hit && code == 4'd0) begin
                code = 4'(i + 1);
            end
        end
        return code;
    endfunction

endpackage

### hw/rtl/toy_language_lexer_top.sv
// Top level of the toy language lexer: scanner state, token build, result queue.
// Depends on tll_pkg.
//
// Takes one character beat per cycle while s_ready is high and returns tokens on the m_
// channel; the character that ends a token writes it into the result queue. A character
// causes zero, one or two tokens; each token is one output beat, so a character that ends
// a word with a single-character symbol gives two output beats. Tokens sit in a
// four-entry queue and s_ready is low while fewer than two entries are free, so with
// m_ready held high the block sustains one character per cycle. The two-character
// symbols == != >= <= := are resolved on the following character; a lone : or ! gives
// no token. An end beat flushes whatever is pending and restarts positions at zero.
module toy_language_lexer_top #(
    parameter int KEYWORD_BUFFER = 5
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  tll_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output tll_pkg::out_t m_data
);
    import tll_pkg::*;

    localparam int QDepth = 4;
    localparam int QPtrBits = $clog2(QDepth);
    localparam int QCntBits = $clog2(QDepth + 1);

    localparam logic [7:0] ChPlus   = 8'h2B;
    localparam logic [7:0] ChMinus  = 8'h2D;
    localparam logic [7:0] ChStar   = 8'h2A;
    localparam logic [7:0] ChSlash  = 8'h2F;
    localparam logic [7:0] ChLParen = 8'h28;
    localparam logic [7:0] ChRParen = 8'h29;
    localparam logic [7:0] ChLBrack = 8'h5B;
    localparam logic [7:0] ChRBrack = 8'h5D;
    localparam logic [7:0] ChSemi   = 8'h3B;
    localparam logic [7:0] ChEq     = 8'h3D;
    localparam logic [7:0] ChBang   = 8'h21;
    localparam logic [7:0] ChGt     = 8'h3E;
    localparam logic [7:0] ChLt     = 8'h3C;
    localparam logic [7:0] ChColon  = 8'h3A;
    localparam logic [7:0] ChDot    = 8'h2E;
    localparam logic [7:0] ChSpace  = 8'h20;
    localparam logic [7:0] ChTab    = 8'h09;
    localparam logic [7:0] ChCr     = 8'h0D;
    localparam logic [7:0] ChZero   = 8'h30;
    localparam logic [7:0] ChNine   = 8'h39;

    // scanner state
    logic [PosBits-1:0] char_index_reg, char_index_next;
    held_t              held_reg, held_next;
    logic [7:0]         word_chars_reg [KEYWORD_BUFFER];
    logic [PosBits-1:0] word_length_reg, word_length_next;
    logic [PosBits-1:0] word_start_reg, word_start_next;
    class_t             first_class_reg, first_class_next;
    logic               dot_seen_reg, dot_seen_next;
    logic               bad_reg, bad_next;
    logic [31:0]        int_acc_reg, int_acc_next;
    logic [29:0]        frac_acc_reg, frac_acc_next;
    logic [3:0]         frac_kept_reg, frac_kept_next;

    // result queue
    out_t                q_mem_reg [QDepth];
    logic [QPtrBits-1:0] q_wr_reg, q_rd_reg;
    logic [QCntBits-1:0] q_cnt_reg;

    logic        accept, pop, char_write;
    logic [7:0]  c;
    logic        is_end, is_space, is_alpha, is_digit, with_eq;
    sym_t        single_sym, held_sym;
    kind_t       single_kind, held_kind;
    held_t       hold_code;
    logic [3:0]  kw_code;
    logic [8*KwMaxLen-1:0] word_text;
    logic [35:0] int_wide;
    logic [3:0]  digit;
    out_t        held_tok, word_tok, single_tok, first_tok, second_tok;
    logic        first_v, second_v;
    out_t        push0, push1;
    logic [1:0]  push_n;

    assign accept   = s_valid && s_ready;
    assign pop      = m_valid && m_ready;
    assign s_ready  = q_cnt_reg <= QCntBits'(QDepth - 2);
    assign m_valid  = q_cnt_reg != '0;
    assign m_data   = q_mem_reg[q_rd_reg];

    assign c        = s_data.character;
    assign is_end   = s_data.end_of_input;
    assign is_space = (c == ChSpace) || (c >= ChTab && c <= ChCr);
    assign is_alpha = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    assign is_digit = (c >= ChZero && c <= ChNine);
    assign digit    = 4'(c - ChZero);
    assign with_eq  = !is_end && (c == ChEq);

    always_comb begin
        for (int j = 0; j < KwMaxLen; j++) begin
            word_text[8*j +: 8] = word_chars_reg[j];
        end
    end
    assign kw_code = keyword_of(word_text, word_length_reg);

    always_comb begin
        single_sym  = SymNone;
        single_kind = KindOperator;
        hold_code   = HeldNone;
        unique case (c)
            ChPlus: single_sym = SymPlus;
            ChMinus: single_sym = SymMinus;
            ChStar: single_sym = SymStar;
            ChSlash: single_sym = SymSlash;
            ChLParen: begin
                single_sym  = SymLParen;
                single_kind = KindOpenParen;
            end
            ChRParen: begin
                single_sym  = SymRParen;
                single_kind = KindCloseParen;
            end
            ChLBrack: begin
                single_sym  = SymLBracket;
                single_kind = KindBracket;
            end
            ChRBrack: begin
                single_sym  = SymRBracket;
                single_kind = KindBracket;
            end
            ChSemi: begin
                single_sym  = SymSemi;
                single_kind = KindSemicolon;
            end
            ChEq: hold_code = HeldEq;
            ChBang: hold_code = HeldBang;
            ChGt: hold_code = HeldGt;
            ChLt: hold_code = HeldLt;
            ChColon: hold_code = HeldColon;
            default: ;
        endcase
    end

    always_comb begin
        held_kind = KindComparison;
        unique case (held_reg)
            HeldEq: held_sym = with_eq ? SymEqEq : SymEq;
            HeldBang: held_sym = with_eq ? SymNe : SymNone;
            HeldGt: held_sym = with_eq ? SymGe : SymGt;
            HeldLt: held_sym = with_eq ? SymLe : SymLt;
            HeldColon: begin
                held_sym  = with_eq ? SymAssign : SymNone;
                held_kind = KindAssignment;
            end
            default: held_sym = SymNone;
        endcase
    end

    always_comb begin
        held_tok = '0;
        held_tok.token_kind     = held_kind;
        held_tok.symbol_code    = held_sym;
        held_tok.start_position = word_start_reg;
        held_tok.token_length   = with_eq ? PosBits'(2) : PosBits'(1);

        single_tok = '0;
        single_tok.token_kind     = single_kind;
        single_tok.symbol_code    = single_sym;
        single_tok.start_position = char_index_reg;
        single_tok.token_length   = PosBits'(1);

        word_tok = '0;
        word_tok.start_position = word_start_reg;
        word_tok.token_length   = word_length_reg;
        if (kw_code != 4'd0) begin
            word_tok.token_kind   = KindKeyword;
            word_tok.keyword_code = kw_code;
        end else if (first_class_reg == ClassAlpha) begin
            word_tok.token_kind = KindIdentifier;
        end else if (first_class_reg == ClassDigit && !bad_reg) begin
            word_tok.integer_part = int_acc_reg;
            if (dot_seen_reg) begin
                word_tok.token_kind      = KindFloat;
                word_tok.fraction_digits = frac_acc_reg;
                word_tok.fraction_count  = frac_kept_reg;
            end else begin
                word_tok.token_kind = KindNumber;
            end
        end else begin
            word_tok.token_kind = KindMistake;
        end
    end

    assign int_wide = ({4'd0, int_acc_reg} << 3) + ({4'd0, int_acc_reg} << 1)
                      + {32'd0, digit};

    always_comb begin
        char_index_next  = char_index_reg;
        held_next        = held_reg;
        word_length_next = word_length_reg;
        word_start_next  = word_start_reg;
        first_class_next = first_class_reg;
        dot_seen_next    = dot_seen_reg;
        bad_next         = bad_reg;
        int_acc_next     = int_acc_reg;
        frac_acc_next    = frac_acc_reg;
        frac_kept_next   = frac_kept_reg;
        first_tok        = held_tok;
        first_v          = 1'b0;
        second_v         = 1'b0;
        char_write       = 1'b0;

        if (accept) begin
            if (is_end) begin
                if (held_reg != HeldNone) begin
                    first_v = held_sym != SymNone;
                end else begin
                    first_tok = word_tok;
                    first_v   = word_length_reg != '0;
                end
                char_index_next  = '0;
                held_next        = HeldNone;
                word_start_next  = '0;
                word_length_next = '0;
                first_class_next = ClassAlpha;
                dot_seen_next    = 1'b0;
                bad_next         = 1'b0;
                int_acc_next     = '0;
                frac_acc_next    = '0;
                frac_kept_next   = '0;
            end else begin
                if (held_reg != HeldNone) begin
                    first_v   = held_sym != SymNone;
                    held_next = HeldNone;
                end
                if (held_reg != HeldNone && with_eq) begin
                    // pair completed; the = is consumed
                end else if (single_sym != SymNone || hold_code != HeldNone || is_space) begin
                    if (word_length_reg != '0) begin
                        first_tok        = word_tok;
                        first_v          = 1'b1;
                        word_length_next = '0;
                        first_class_next = ClassAlpha;
                        dot_seen_next    = 1'b0;
                        bad_next         = 1'b0;
                        int_acc_next     = '0;
                        frac_acc_next    = '0;
                        frac_kept_next   = '0;
                    end
                    if (single_sym != SymNone) begin
                        second_v = 1'b1;
                    end else if (hold_code != HeldNone) begin
                        held_next       = hold_code;
                        word_start_next = char_index_reg;
                    end
                end else begin
                    char_write = 1'b1;
                    if (word_length_reg == '0) begin
                        word_start_next  = char_index_reg;
                        first_class_next = is_alpha ? ClassAlpha
                                         : (is_digit ? ClassDigit : ClassOther);
                    end
                    if (word_length_reg != PosMax) begin
                        word_length_next = word_length_reg + PosBits'(1);
                    end
                    if (is_digit) begin
                        if (dot_seen_reg) begin
                            if (frac_kept_reg < 4'd9) begin
                                frac_acc_next  = 30'(({2'd0, frac_acc_reg} << 3)
                                                 + ({2'd0, frac_acc_reg} << 1)
                                                 + {28'd0, digit});
                                frac_kept_next = frac_kept_reg + 4'd1;
                            end
                        end else begin
                            int_acc_next = (int_wide[35:32] != 4'd0) ? 32'hFFFF_FFFF
                                                                     : int_wide[31:0];
                        end
                    end else if (c == ChDot) begin
                        if (dot_seen_reg) begin
                            bad_next = 1'b1;
                        end
                        dot_seen_next = 1'b1;
                    end else begin
                        bad_next = 1'b1;
                    end
                end
                if (char_index_reg != PosMax) begin
                    char_index_next = char_index_reg + PosBits'(1);
                end
            end
        end
    end

    always_comb begin
        second_tok = single_tok;
        if (first_v) begin
            push0  = first_tok;
            push1  = second_tok;
            push_n = second_v ? 2'd2 : 2'd1;
        end else begin
            push0  = second_tok;
            push1  = second_tok;
            push_n = second_v ? 2'd1 : 2'd0;
        end
        push0.last_of_run = push_n == 2'd1;
        push1.last_of_run = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            char_index_reg  <= '0;
            held_reg        <= HeldNone;
            word_length_reg <= '0;
            word_start_reg  <= '0;
            first_class_reg <= ClassAlpha;
            dot_seen_reg    <= 1'b0;
            bad_reg         <= 1'b0;
            int_acc_reg     <= '0;
            frac_acc_reg    <= '0;
            frac_kept_reg   <= '0;
            q_wr_reg        <= '0;
            q_rd_reg        <= '0;
            q_cnt_reg       <= '0;
        end else begin
            char_index_reg  <= char_index_next;
            held_reg        <= held_next;
            word_length_reg <= word_length_next;
            word_start_reg  <= word_start_next;
            first_class_reg <= first_class_next;
            dot_seen_reg    <= dot_seen_next;
            bad_reg         <= bad_next;
            int_acc_reg     <= int_acc_next;
            frac_acc_reg    <= frac_acc_next;
            frac_kept_reg   <= frac_kept_next;
            q_wr_reg        <= q_wr_reg + QPtrBits'(push_n);
            q_rd_reg        <= q_rd_reg + QPtrBits'(pop);
            q_cnt_reg       <= q_cnt_reg + QCntBits'(push_n) - QCntBits'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < KEYWORD_BUFFER; i++) begin
            if (char_write && word_length_reg == PosBits'(i)) begin
                word_chars_reg[i] <= c;
            end
        end
        if (push_n != 2'd0) begin
            q_mem_reg[q_wr_reg] <= push0;
        end
        if (push_n == 2'd2) begin
            q_mem_reg[q_wr_reg + QPtrBits'(1)] <= push1;
        end
    end

endmodule
